// File: sv/kpsw_pkg.sv
// Shared types and constants for the keypad stopwatch controller.
// No dependencies; imported by kpsw_step and keypad_stopwatch_controller_core.
`default_nettype none

package kpsw_pkg;

    localparam int SEC_W = 9;

    localparam logic [7:0] KEY_START  = 8'd0;
    localparam logic [7:0] KEY_STOP   = 8'd1;
    localparam logic [7:0] KEY_RESET  = 8'd2;
    localparam logic [7:0] KEY_HIDE   = 8'd3;
    localparam logic [7:0] KEY_TOGGLE = 8'd4;

    localparam logic [15:0] HIDE_INTERVAL_RESET = 16'd2000;
    localparam logic [15:0] HIDE_ELAPSED_MAX    = 16'hFFFF;
    localparam logic [3:0]  DIGIT_MAX           = 4'd9;
    localparam logic [5:0]  SEC_IN_MIN_MAX      = 6'd59;
    localparam logic [6:0]  DEC_BASE            = 7'd10;

    // Millisecond count is kept as decimal digits d2 d1 d0 (only its low three
    // digits are ever shown); seconds as full count plus minute split.
    typedef struct packed {
        logic             key_armed;
        logic             running;
        logic             shown;
        logic             hide_active;
        logic [15:0]      hide_elapsed;
        logic [SEC_W-1:0] sec;
        logic [5:0]       sec_lo;
        logic [2:0]       sec_min;
        logic [3:0]       ms_d0;
        logic [3:0]       ms_d1;
        logic [3:0]       ms_d2;
        logic [7:0]       led;
        logic [3:0]       tenths;
        logic             text_valid;
        logic [2:0]       text_min;
        logic [5:0]       text_sec;
        logic [6:0]       text_hund;
    } t_state;

    localparam t_state STATE_RESET = '{key_armed: 1'b1, default: '0};

endpackage

`default_nettype wire

// File: sv/kpsw_step.sv
// Next-state logic for one millisecond tick: key edge decode, counting,
// display latch refresh and hide timeout. Depends on kpsw_pkg.
`default_nettype none

module kpsw_step #(
    parameter int LED_COUNT     = 8,
    parameter int SECONDS_LIMIT = 256,
    parameter int MS_PER_SECOND = 1000
) (
    input  kpsw_pkg::t_state i_state,
    input  logic [((MS_PER_SECOND > 1) ? $clog2(MS_PER_SECOND) : 1)-1:0] i_ms_sub,
    input  logic             i_key_pressed,
    input  logic [7:0]       i_key_code,
    input  logic [15:0]      i_hide_interval,
    output kpsw_pkg::t_state o_state,
    output logic [((MS_PER_SECOND > 1) ? $clog2(MS_PER_SECOND) : 1)-1:0] o_ms_sub
);
    import kpsw_pkg::*;

    localparam int MS_SUB_W = (MS_PER_SECOND > 1) ? $clog2(MS_PER_SECOND) : 1;
    localparam logic [MS_SUB_W-1:0] MS_SUB_LAST = MS_SUB_W'(MS_PER_SECOND - 1);
    localparam logic [SEC_W-1:0]    SEC_LIMIT   = SEC_W'(SECONDS_LIMIT);

    t_state              s;
    logic [MS_SUB_W-1:0] ms;
    logic                restarted;
    logic                do_refresh;
    logic                counting;
    logic                sec_carry;

    always_comb begin
        s          = i_state;
        ms         = i_ms_sub;
        restarted  = 1'b0;
        do_refresh = 1'b0;
        sec_carry  = 1'b0;

        if (s.hide_active && s.hide_elapsed != HIDE_ELAPSED_MAX) begin
            s.hide_elapsed = s.hide_elapsed + 16'd1;
        end

        if (i_key_pressed && i_state.key_armed) begin
            unique case (i_key_code)
                KEY_START: begin
                    s         = STATE_RESET;
                    ms        = '0;
                    s.running = 1'b1;
                    s.shown   = 1'b1;
                    restarted = 1'b1;
                end
                KEY_STOP: begin
                    s.shown       = 1'b1;
                    s.running     = 1'b0;
                    s.hide_active = 1'b0;
                    do_refresh    = 1'b1;
                end
                KEY_RESET: begin
                    s  = STATE_RESET;
                    ms = '0;
                end
                KEY_HIDE: begin
                    if (s.running) begin
                        s.shown        = 1'b0;
                        s.hide_elapsed = '0;
                        s.hide_active  = 1'b1;
                    end
                end
                KEY_TOGGLE: begin
                    s.shown = !s.shown;
                end
                default: begin
                    s.running     = 1'b0;
                    s.hide_active = 1'b0;
                    do_refresh    = 1'b1;
                end
            endcase
        end
        s.key_armed = !i_key_pressed;

        counting = s.running && (s.sec < SEC_LIMIT);

        // advance the millisecond digits and sub-second count
        if (counting && !restarted) begin
            if (s.ms_d0 == DIGIT_MAX) begin
                s.ms_d0 = '0;
                if (s.ms_d1 == DIGIT_MAX) begin
                    s.ms_d1 = '0;
                    s.ms_d2 = (s.ms_d2 == DIGIT_MAX) ? 4'd0 : s.ms_d2 + 4'd1;
                end else begin
                    s.ms_d1 = s.ms_d1 + 4'd1;
                end
            end else begin
                s.ms_d0 = s.ms_d0 + 4'd1;
            end
            if (ms == MS_SUB_LAST) begin
                ms        = '0;
                sec_carry = 1'b1;
            end else begin
                ms = ms + MS_SUB_W'(1);
            end
        end

        // display refresh uses the seconds count from before this tick
        if (do_refresh || counting) begin
            s.text_valid = 1'b1;
            s.text_min   = s.sec_min;
            s.text_sec   = s.sec_lo;
            s.text_hund  = {3'd0, s.ms_d2} * DEC_BASE + {3'd0, s.ms_d1};
            if (s.shown) begin
                for (int i = 0; i < 8; i++) begin
                    if (i < LED_COUNT) begin
                        s.led[i] = s.sec[i];
                    end
                end
                s.tenths = s.ms_d2;
            end
        end

        if (counting) begin
            if (s.hide_active && s.hide_elapsed >= i_hide_interval) begin
                s.hide_active = 1'b0;
                s.shown       = 1'b1;
            end
            if (sec_carry) begin
                s.sec = s.sec + SEC_W'(1);
                if (s.sec_lo == SEC_IN_MIN_MAX) begin
                    s.sec_lo  = '0;
                    s.sec_min = s.sec_min + 3'd1;
                end else begin
                    s.sec_lo = s.sec_lo + 6'd1;
                end
            end
        end

        o_state  = s;
        o_ms_sub = ms;
    end

endmodule

`default_nettype wire

// File: sv/keypad_stopwatch_controller_core.sv
// Keypad stopwatch controller top level: input beat register, state and
// result register, hide interval register. Depends on kpsw_pkg and kpsw_step.
`default_nettype none

// One input beat is one millisecond tick with the sampled key. The block takes
// one beat per clock while o_in_stall is low; each beat passes the input
// register, then the state/result register, and the state update is a single
// pass of next-state logic between them. A stalled result holds the pipeline;
// the input side stalls only when its register is full and the result cannot
// move. The hide interval is written through i_cfg_we/i_cfg_wdata only while
// the block is idle; the user must keep to this, the block does not enforce it.

module keypad_stopwatch_controller_core #(
    parameter int LED_COUNT     = 8,
    parameter int SECONDS_LIMIT = 256,
    parameter int MS_PER_SECOND = 1000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_key_pressed,
    input  logic [7:0]  i_key_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_led_bits,
    output logic [3:0]  o_tenths_digit,
    output logic [2:0]  o_text_minutes,
    output logic [5:0]  o_text_seconds,
    output logic [6:0]  o_text_hundredths,
    output logic        o_text_valid,
    output logic        o_display_shown,
    output logic        o_is_running
);
    import kpsw_pkg::*;

    localparam int MS_SUB_W = (MS_PER_SECOND > 1) ? $clog2(MS_PER_SECOND) : 1;

    logic                r_in_valid;
    logic                r_in_pressed;
    logic [7:0]          r_in_code;
    logic                r_out_valid;
    logic [15:0]         r_hide_interval;
    t_state              r_state;
    logic [MS_SUB_W-1:0] r_ms_sub;

    t_state              n_state;
    logic [MS_SUB_W-1:0] n_ms_sub;
    logic                w_advance;

    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;

    kpsw_step #(
        .LED_COUNT    (LED_COUNT),
        .SECONDS_LIMIT(SECONDS_LIMIT),
        .MS_PER_SECOND(MS_PER_SECOND)
    ) u_step (
        .i_state        (r_state),
        .i_ms_sub       (r_ms_sub),
        .i_key_pressed  (r_in_pressed),
        .i_key_code     (r_in_code),
        .i_hide_interval(r_hide_interval),
        .o_state        (n_state),
        .o_ms_sub       (n_ms_sub)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_pressed <= i_key_pressed;
            r_in_code    <= i_key_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hide_interval <= HIDE_INTERVAL_RESET;
        end else if (i_cfg_we) begin
            r_hide_interval <= i_cfg_wdata;
        end
    end

    // state doubles as the result payload; it moves only with a result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
            r_ms_sub    <= '0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state  <= n_state;
                r_ms_sub <= n_ms_sub;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_led_bits        = r_state.led;
    assign o_tenths_digit    = r_state.tenths;
    assign o_text_minutes    = r_state.text_min;
    assign o_text_seconds    = r_state.text_sec;
    assign o_text_hundredths = r_state.text_hund;
    assign o_text_valid      = r_state.text_valid;
    assign o_display_shown   = r_state.shown;
    assign o_is_running      = r_state.running;

    a_blank_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.text_valid |-> (r_state.text_min == 3'd0 && r_state.text_sec == 6'd0
                                 && r_state.text_hund == 7'd0))
        else $error("blanked clock text carries nonzero fields");

    a_sec_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.sec_lo <= SEC_IN_MIN_MAX)
        && ({6'd0, r_state.sec_min} * 9'd60 + {3'd0, r_state.sec_lo} == r_state.sec))
        else $error("minute split out of step with seconds count");

    a_ms_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.ms_d0 <= DIGIT_MAX && r_state.ms_d1 <= DIGIT_MAX
        && r_state.ms_d2 <= DIGIT_MAX && r_state.tenths <= DIGIT_MAX)
        else $error("millisecond digit out of range");

    a_beat_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_advance) |=> r_out_valid)
        else $error("accepted tick produced no result beat");

endmodule

`default_nettype wire

// File: tb/tb_keypad_stopwatch_controller_core.sv
// Self-checking testbench for keypad_stopwatch_controller_core: key tables, random key
// sequences and a full-rate counting run, checked against a tick-level predictor.
// Depends on kpsw_pkg and keypad_stopwatch_controller_core.

module tb_keypad_stopwatch_controller_core;
    import kpsw_pkg::*;

    localparam int SECONDS_LIMIT = 256;
    localparam int MS_PER_SECOND = 1000;
    localparam int MAX_GAP       = 17;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RUN_TICKS     = 150;

    typedef struct packed {
        logic [7:0] led_bits;
        logic [3:0] tenths_digit;
        logic [2:0] text_minutes;
        logic [5:0] text_seconds;
        logic [6:0] text_hundredths;
        logic       text_valid;
        logic       display_shown;
        logic       is_running;
    } t_readout;

    typedef struct packed {
        logic       pressed;
        logic [7:0] code;
        logic       pinned;
        t_readout   want;
    } t_drill;

    localparam t_readout RD_BLANK   = '0;
    localparam t_readout RD_STARTED = '{8'd0, 4'd0, 3'd0, 6'd0, 7'd0, 1'b1, 1'b1, 1'b1};
    localparam t_readout RD_HALTED  = '{8'd0, 4'd0, 3'd0, 6'd0, 7'd0, 1'b1, 1'b0, 1'b0};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [15:0] i_cfg_wdata   = '0;
    logic        i_in_valid    = 1'b0;
    logic        i_key_pressed = 1'b0;
    logic [7:0]  i_key_code    = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_led_bits;
    logic [3:0]  o_tenths_digit;
    logic [2:0]  o_text_minutes;
    logic [5:0]  o_text_seconds;
    logic [6:0]  o_text_hundredths;
    logic        o_text_valid;
    logic        o_display_shown;
    logic        o_is_running;

    keypad_stopwatch_controller_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_key_pressed     (i_key_pressed),
        .i_key_code        (i_key_code),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_led_bits        (o_led_bits),
        .o_tenths_digit    (o_tenths_digit),
        .o_text_minutes    (o_text_minutes),
        .o_text_seconds    (o_text_seconds),
        .o_text_hundredths (o_text_hundredths),
        .o_text_valid      (o_text_valid),
        .o_display_shown   (o_display_shown),
        .o_is_running      (o_is_running)
    );

    always #6 i_clk = ~i_clk;

    t_readout    due_readouts[$];
    int unsigned ticks_sent    = 0;
    int unsigned readouts_seen = 0;
    int unsigned n_bad         = 0;
    logic        src_pace      = 1'b1;
    logic        sink_pace     = 1'b1;

    // predicted stopwatch state
    logic        sw_armed, sw_running, sw_shown, sw_hiding;
    logic [15:0] sw_hide_ms, sw_hide_limit;
    logic [17:0] sw_ms;
    logic [8:0]  sw_sec;
    t_readout    sw_face;

    function automatic void latch_display();
        sw_face.text_valid      = 1'b1;
        sw_face.text_minutes    = 3'((sw_sec / 60) & 7);
        sw_face.text_seconds    = 6'(sw_sec % 60);
        sw_face.text_hundredths = 7'((sw_ms / 10) % 100);
        if (sw_shown) begin
            sw_face.led_bits     = sw_sec[7:0];
            sw_face.tenths_digit = 4'((sw_ms / 100) % 10);
        end
    endfunction

    function automatic void halt_count();
        sw_running = 1'b0;
        sw_hiding  = 1'b0;
        latch_display();
    endfunction

    function automatic void clear_counts();
        sw_ms      = '0;
        sw_sec     = '0;
        sw_running = 1'b0;
        sw_shown   = 1'b0;
        sw_hiding  = 1'b0;
        sw_hide_ms = '0;
        sw_face    = '0;
    endfunction

    function automatic t_readout stopwatch_tick(input logic pressed, input logic [7:0] code);
        logic     restarted;
        t_readout r;
        restarted = 1'b0;
        if (sw_hiding && sw_hide_ms != HIDE_ELAPSED_MAX)
            sw_hide_ms = sw_hide_ms + 16'd1;
        if (!pressed) begin
            sw_armed = 1'b1;
        end else if (sw_armed) begin
            sw_armed = 1'b0;
            case (code)
                KEY_START: begin
                    clear_counts();
                    sw_running = 1'b1;
                    sw_shown   = 1'b1;
                    restarted  = 1'b1;
                end
                KEY_STOP: begin
                    sw_shown = 1'b1;
                    halt_count();
                end
                KEY_RESET: begin
                    sw_shown = 1'b0;
                    halt_count();
                    clear_counts();
                end
                KEY_HIDE: begin
                    if (sw_running) begin
                        sw_shown   = 1'b0;
                        sw_hide_ms = '0;
                        sw_hiding  = 1'b1;
                    end
                end
                KEY_TOGGLE: sw_shown = !sw_shown;
                default: halt_count();
            endcase
        end
        // seconds follow the display refresh, so the text lags by one tick
        if (sw_running && sw_sec < SECONDS_LIMIT) begin
            if (!restarted)
                sw_ms = sw_ms + 18'd1;
            latch_display();
            if (sw_hiding && sw_hide_ms >= sw_hide_limit) begin
                sw_hiding = 1'b0;
                sw_shown  = 1'b1;
            end
            sw_sec = 9'(sw_ms / MS_PER_SECOND);
        end
        r               = sw_face;
        r.display_shown = sw_shown;
        r.is_running    = sw_running;
        return r;
    endfunction

    function automatic string show_readout(input t_readout r);
        return $sformatf("led=%0d tenths=%0d text=%0d:%0d.%0d valid=%0d shown=%0d run=%0d",
                         r.led_bits, r.tenths_digit, r.text_minutes, r.text_seconds,
                         r.text_hundredths, r.text_valid, r.display_shown, r.is_running);
    endfunction

    task automatic feed_tick(input logic pressed, input logic [7:0] code,
                             input logic pinned, input t_readout want);
        t_readout calc;
        int       gap;
        calc = stopwatch_tick(pressed, code);
        due_readouts.push_back(pinned ? want : calc);
        gap = src_pace ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_key_pressed <= pressed;
        i_key_code    <= code;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (due_readouts.size() != 0);
    endtask

    task automatic set_hide_interval(input logic [15:0] ms);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ms;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sw_hide_limit = ms;
    endtask

    // press-hold-release episodes with random content, plus some raw noise
    task automatic key_episodes(input int unsigned n);
        int unsigned goal;
        int          r, held, rest;
        logic [7:0]  key;
        goal = ticks_sent + n;
        while (ticks_sent < goal) begin
            if ($urandom_range(0, 14) == 0) begin
                src_pace  = ($urandom_range(0, 3) != 0);
                sink_pace = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 9) == 0) begin
                feed_tick(1'($urandom_range(0, 1)), 8'($urandom), 1'b0, RD_BLANK);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 18)      key = KEY_START;
                else if (r < 26) key = KEY_STOP;
                else if (r < 30) key = KEY_RESET;
                else if (r < 62) key = KEY_HIDE;
                else if (r < 88) key = KEY_TOGGLE;
                else             key = 8'($urandom);
                held = $urandom_range(1, 3);
                rest = $urandom_range(1, 40);
                feed_tick(1'b1, key, 1'b0, RD_BLANK);
                repeat (held - 1)
                    feed_tick(1'b1, ($urandom_range(0, 3) == 0) ? 8'($urandom) : key,
                              1'b0, RD_BLANK);
                repeat (rest) feed_tick(1'b0, 8'($urandom), 1'b0, RD_BLANK);
            end
        end
    endtask

    initial begin : sink
        t_readout got;
        t_readout want;
        int       hold;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = {o_led_bits, o_tenths_digit, o_text_minutes, o_text_seconds,
                       o_text_hundredths, o_text_valid, o_display_shown, o_is_running};
                readouts_seen++;
                if (due_readouts.size() == 0) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS)
                        $display("beat %0d unexpected: %s", readouts_seen, show_readout(got));
                end else begin
                    want = due_readouts.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= MAX_REPORTS) begin
                            $display("beat %0d expected %s", readouts_seen, show_readout(want));
                            $display("beat %0d actual   %s", readouts_seen, show_readout(got));
                        end
                    end
                end
                hold = sink_pace ? $urandom_range(0, MAX_GAP) : 0;
                if (hold > 0) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                    repeat (hold) @(negedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("keypad_stopwatch_controller_core: mismatch");
        $finish;
    end

    initial begin : stimulus
        t_drill drill[$];
        sw_armed      = 1'b1;
        sw_hide_limit = HIDE_INTERVAL_RESET;
        clear_counts();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        drill.push_back('{1'b0, 8'h00,      1'b1, RD_BLANK});
        drill.push_back('{1'b1, KEY_START,  1'b1, RD_STARTED});
        drill.push_back('{1'b0, 8'hFF,      1'b0, RD_BLANK});
        drill.push_back('{1'b1, KEY_HIDE,   1'b0, RD_BLANK});
        drill.push_back('{1'b1, KEY_HIDE,   1'b0, RD_BLANK});
        drill.push_back('{1'b1, KEY_START,  1'b0, RD_BLANK});
        drill.push_back('{1'b0, 8'h00,      1'b0, RD_BLANK});
        drill.push_back('{1'b1, KEY_TOGGLE, 1'b0, RD_BLANK});
        drill.push_back('{1'b0, 8'hAA,      1'b0, RD_BLANK});
        drill.push_back('{1'b1, KEY_TOGGLE, 1'b0, RD_BLANK});
        drill.push_back('{1'b0, 8'h55,      1'b0, RD_BLANK});
        drill.push_back('{1'b1, KEY_STOP,   1'b0, RD_BLANK});
        drill.push_back('{1'b0, 8'h00,      1'b0, RD_BLANK});
        drill.push_back('{1'b1, KEY_HIDE,   1'b0, RD_BLANK});
        drill.push_back('{1'b0, 8'h00,      1'b0, RD_BLANK});
        drill.push_back('{1'b1, KEY_TOGGLE, 1'b0, RD_BLANK});
        drill.push_back('{1'b0, 8'h00,      1'b0, RD_BLANK});
        drill.push_back('{1'b1, KEY_RESET,  1'b1, RD_BLANK});
        drill.push_back('{1'b0, 8'h00,      1'b1, RD_BLANK});
        drill.push_back('{1'b1, 8'hFF,      1'b1, RD_HALTED});
        drill.push_back('{1'b0, 8'h00,      1'b1, RD_HALTED});
        drill.push_back('{1'b1, 8'h05,      1'b0, RD_BLANK});
        drill.push_back('{1'b0, 8'h7F,      1'b0, RD_BLANK});
        drill.push_back('{1'b1, KEY_START,  1'b1, RD_STARTED});
        drill.push_back('{1'b1, 8'h80,      1'b0, RD_BLANK});
        drill.push_back('{1'b0, 8'h01,      1'b0, RD_BLANK});
        foreach (drill[k])
            feed_tick(drill[k].pressed, drill[k].code, drill[k].pinned, drill[k].want);

        settle();
        set_hide_interval(16'd1);
        key_episodes(500);

        settle();
        set_hide_interval(16'($urandom_range(2, 50)));
        key_episodes(250);
        settle();
        key_episodes(250);

        // full-rate counting run under a hide that outlasts it, then toggle and stop
        settle();
        set_hide_interval(HIDE_ELAPSED_MAX);
        src_pace  = 1'b0;
        sink_pace = 1'b0;
        feed_tick(1'b1, KEY_START, 1'b0, RD_BLANK);
        feed_tick(1'b0, 8'($urandom), 1'b0, RD_BLANK);
        feed_tick(1'b1, KEY_HIDE, 1'b0, RD_BLANK);
        repeat (RUN_TICKS) feed_tick(1'b0, 8'($urandom), 1'b0, RD_BLANK);
        feed_tick(1'b1, KEY_TOGGLE, 1'b0, RD_BLANK);
        feed_tick(1'b0, 8'($urandom), 1'b0, RD_BLANK);
        feed_tick(1'b1, KEY_STOP, 1'b0, RD_BLANK);
        feed_tick(1'b0, 8'($urandom), 1'b0, RD_BLANK);

        settle();
        set_hide_interval(16'($urandom_range(51, 400)));
        src_pace  = 1'b1;
        sink_pace = 1'b1;
        key_episodes(300);

        settle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (due_readouts.size() != 0)
            n_bad++;
        $display("%0d ticks sent, %0d readouts checked, %0d bad", ticks_sent, readouts_seen,
                 n_bad);
        $display("covered all keys, held keys, hide intervals 1 to 65535, gapless and stalled beats");
        if (n_bad == 0)
            $display("keypad_stopwatch_controller_core: match");
        else
            $display("keypad_stopwatch_controller_core: mismatch");
        $finish;
    end

endmodule
